/* rtl/packet_replay_scheduler_census_unit_defines.svh */
// assertion macros for the packet replay scheduler census unit
`ifndef PACKET_REPLAY_SCHEDULER_CENSUS_UNIT_DEFINES_SVH
`define PACKET_REPLAY_SCHEDULER_CENSUS_UNIT_DEFINES_SVH

// condition must hold in the same cycle
`define PRSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the next cycle
`define PRSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/prsc_pkg.sv */
// shared types and constants for the packet replay scheduler census unit
package prsc_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 256;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned TIME_W  = 64;
	localparam int unsigned OFS_W   = 64;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned ID_W    = 16;
	localparam int unsigned DELAY_W = 55;
	localparam int unsigned PB_W    = 40;
	localparam int unsigned DIST_W  = 9;
	localparam int unsigned REM_W   = 10;

	localparam int unsigned CHUNK_W     = 16;
	localparam int unsigned CHUNK_IDX_W = 2;
	localparam int unsigned PART_W      = REM_W + CHUNK_W;
	localparam int unsigned RECIP_W     = 27;
	localparam int unsigned RECIP_SH    = 36;

	localparam logic [REM_W-1:0]       NS_PER_US      = 10'd1000;
	localparam logic [OFS_W-1:0]       OFS_ZERO_FILL  = 64'hffff_ffff_ffff_ffff;
	localparam logic [RECIP_W-1:0]     RECIP_1000     = 27'd68719477;
	localparam logic [CHUNK_IDX_W-1:0] DIV_LAST_CHUNK = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic shift;
		logic wr_en;
	} cell_ctrl_t;

	typedef struct packed {
		logic              busy;
		logic [TIME_W-1:0] quot;
		logic [REM_W-1:0]  rem;
	} div_res_t;

endpackage

/* rtl/prsc_if.sv */
// request channel interfaces: header in, schedule result out, register write
interface prsc_hdr_if import prsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              first_header;
	logic [TIME_W-1:0] send_ns;
	logic [OFS_W-1:0]  byte_offset;
	logic [LEN_W-1:0]  data_length;
	logic [ID_W-1:0]   station_id;
	logic [ID_W-1:0]   logical_channel;

	modport source (output valid, first_header, send_ns, byte_offset, data_length,
		station_id, logical_channel, input ready);
	modport sink (input valid, first_header, send_ns, byte_offset, data_length,
		station_id, logical_channel, output ready);
endinterface

interface prsc_res_if import prsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DELAY_W-1:0] delay_us;
	logic               zero_fill;
	logic [OFS_W-1:0]   payload_offset;
	logic [LEN_W-1:0]   payload_length;
	logic               range_error;
	logic [DIST_W-1:0]  distinct_channels;
	logic               census_overflow;

	modport source (output valid, delay_us, zero_fill, payload_offset, payload_length,
		range_error, distinct_channels, census_overflow, input ready);
	modport sink (input valid, delay_us, zero_fill, payload_offset, payload_length,
		range_error, distinct_channels, census_overflow, output ready);
endinterface

interface prsc_cfg_if import prsc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PB_W-1:0] payload_bytes;

	modport source (output valid, payload_bytes, input ready);
	modport sink (input valid, payload_bytes, output ready);
endinterface

/* rtl/prsc_cell.sv */
// one census ring cell: holds a station/channel pair, rotates to its neighbor
module prsc_cell import prsc_pkg::*; (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [KEY_W-1:0] nbr_key,
	input  logic [KEY_W-1:0] wr_key,
	output logic [KEY_W-1:0] key
);

	logic [KEY_W-1:0] key_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			key_q <= wr_key;
		end else if (ctrl.shift) begin
			key_q <= nbr_key;
		end
	end

	assign key = key_q;

endmodule

/* rtl/prsc_div.sv */
// divide of a 64-bit time difference by 1000 ns, 16 dividend bits per reciprocal multiply
module prsc_div import prsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	output div_res_t          res
);

	localparam int unsigned PROD_W = PART_W + RECIP_W;

	logic                   busy_q;
	logic                   fold_q;
	logic [CHUNK_IDX_W-1:0] chunk_q;
	logic [TIME_W-1:0]      num_q;
	logic [TIME_W-1:0]      quo_q;
	logic [REM_W-1:0]       rem_q;
	logic [PART_W-1:0]      part;
	logic [PROD_W-1:0]      prod;
	logic [PART_W-1:0]      part_s1;
	logic [PROD_W-1:0]      prod_s1;
	logic [CHUNK_W-1:0]     digit;
	logic [PART_W-1:0]      fold_rem;

	assign part     = {rem_q, num_q[TIME_W-1 -: CHUNK_W]};
	assign prod     = {{RECIP_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP_1000};
	assign digit    = prod_s1[RECIP_SH +: CHUNK_W];
	assign fold_rem = part_s1 - PART_W'(digit) * PART_W'(NS_PER_US);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fold_q  <= 1'b0;
			chunk_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			fold_q  <= 1'b0;
			chunk_q <= '0;
		end else if (busy_q) begin
			fold_q <= !fold_q;
			if (fold_q) begin
				chunk_q <= chunk_q + CHUNK_IDX_W'(1);
				if (chunk_q == DIV_LAST_CHUNK) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
		end else if (busy_q) begin
			if (fold_q) begin
				rem_q <= fold_rem[REM_W-1:0];
				num_q <= {num_q[TIME_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
				quo_q <= {quo_q[TIME_W-CHUNK_W-1:0], digit};
			end else begin
				part_s1 <= part;
				prod_s1 <= prod;
			end
		end
	end

	assign res.busy = busy_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

/* rtl/packet_replay_scheduler_census_unit.sv */
// top level: packet replay scheduler with station/channel census ring
// One header is in work at a time and its result is registered after the census table,
// a ring of TABLE_DEPTH cells, has rotated once past a single comparator and the
// microsecond delay has come from a divide by 1000 made of four 16-bit
// reciprocal-multiply steps, run during the rotation. A new header is taken in the
// cycle after the previous one has moved to the output register, even if that result
// has not yet been taken; a result still waiting when the next is ready holds the
// unit until it drains. The payload size register may be written at any time the
// unit is idle; its write channel is always ready.
`include "packet_replay_scheduler_census_unit_defines.svh"

module packet_replay_scheduler_census_unit import prsc_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	prsc_cfg_if.sink   cfg,
	prsc_hdr_if.sink   hdr,
	prsc_res_if.source res
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	logic [PB_W-1:0]   payload_bytes_q;
	logic [TIME_W-1:0] sched_q;
	logic              run_started_q;
	logic [CW-1:0]     count_q;

	logic [TIME_W-1:0] send_q;
	logic [OFS_W-1:0]  offset_q;
	logic [LEN_W-1:0]  length_q;
	logic [KEY_W-1:0]  key_q;

	logic              err_q;
	logic              hit_q;
	logic              rot_done_q;
	logic [CW-1:0]     step_q;

	logic                out_valid_q;
	logic [DELAY_W-1:0]  delay_q;
	logic                zero_q;
	logic [OFS_W-1:0]    pofs_q;
	logic [LEN_W-1:0]    plen_q;
	logic                rerr_q;
	logic [DIST_W-1:0]   dist_q;
	logic                ovf_q;

	logic accept;
	logic commit;
	logic shift;
	logic div_start;
	logic zero;
	logic err;
	logic insert;
	logic ovf;
	logic [CW-1:0]      count_next;
	logic [CW+DIST_W-1:0] count_ext;
	logic [OFS_W:0]     span;
	logic [TIME_W-1:0]  diff;

	logic [KEY_W-1:0] ring [TABLE_DEPTH];
	div_res_t         div_res;

	// ring of census cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		assign ctrl.shift = shift;
		assign ctrl.wr_en = commit && insert && (count_q == CW'(i));
		prsc_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.nbr_key (ring[(i + 1) % TABLE_DEPTH]),
			.wr_key  (key_q),
			.key     (ring[i])
		);
	end

	prsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.res      (div_res)
	);

	assign accept = hdr.valid && hdr.ready;
	assign hdr.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign zero = (offset_q == OFS_ZERO_FILL);
	assign span = {1'b0, offset_q} + {{(OFS_W - LEN_W + 1){1'b0}}, length_q};
	assign err  = !zero && (span > {{(OFS_W + 1 - PB_W){1'b0}}, payload_bytes_q});
	assign diff = send_q - sched_q;

	assign insert     = !hit_q && (count_q < DEPTH_C);
	assign ovf        = !hit_q && (count_q == DEPTH_C);
	assign count_next = count_q + CW'(insert);
	assign count_ext  = {{DIST_W{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		shift     = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				div_start = !err && run_started_q;
				state_d   = ST_RUN;
			end
			ST_RUN: begin
				shift = !rot_done_q;
				if (rot_done_q && !div_res.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || res.ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_bytes_q <= '0;
			sched_q         <= '0;
			run_started_q   <= 1'b0;
			count_q         <= '0;
			rot_done_q      <= 1'b0;
			hit_q           <= 1'b0;
			step_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				payload_bytes_q <= cfg.payload_bytes;
			end
			if (accept && hdr.first_header) begin
				count_q       <= '0;
				run_started_q <= 1'b0;
			end
			if (state_q == ST_CHECK) begin
				rot_done_q <= 1'b0;
				hit_q      <= 1'b0;
				step_q     <= '0;
			end
			if (shift) begin
				if (step_q < count_q && ring[0] == key_q) begin
					hit_q <= 1'b1;
				end
				if (step_q == LAST_C) begin
					rot_done_q <= 1'b1;
				end else begin
					step_q <= step_q + CW'(1);
				end
			end
			if (commit) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
				if (!err_q) begin
					run_started_q <= 1'b1;
					sched_q <= run_started_q ? send_q - TIME_W'(div_res.rem) : send_q;
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// header and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			send_q   <= hdr.send_ns;
			offset_q <= hdr.byte_offset;
			length_q <= hdr.data_length;
			key_q    <= {hdr.station_id, hdr.logical_channel};
		end
		if (state_q == ST_CHECK) begin
			err_q <= err;
		end
		if (commit) begin
			delay_q <= (!err_q && run_started_q) ? div_res.quot[DELAY_W-1:0] : '0;
			zero_q  <= zero;
			pofs_q  <= offset_q;
			plen_q  <= length_q;
			rerr_q  <= err_q;
			dist_q  <= count_ext[DIST_W-1:0];
			ovf_q   <= ovf;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.delay_us          = delay_q;
	assign res.zero_fill         = zero_q;
	assign res.payload_offset    = pofs_q;
	assign res.payload_length    = plen_q;
	assign res.range_error       = rerr_q;
	assign res.distinct_channels = dist_q;
	assign res.census_overflow   = ovf_q;

	`PRSC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DEPTH_C, "census count past table depth")
	`PRSC_ASSERT_NOW(a_div_idle_done, state_q == ST_DONE, !div_res.busy,
		"divide still busy at commit")
	`PRSC_ASSERT_NOW(a_ovf_full, commit && ovf, count_q == DEPTH_C, "overflow with free table entry")
	`PRSC_ASSERT_NEXT(a_first_clears, accept && hdr.first_header,
		count_q == '0 && !run_started_q, "new run did not restart census")
	`PRSC_ASSERT_NOW(a_err_no_delay, res.valid && res.range_error, res.delay_us == '0,
		"range error with nonzero delay")

endmodule
